### design/srr_pkg.sv
// Shared constants, codes and types of the selective-repeat receiver.
`default_nettype none
package srr_pkg;

	localparam int MAX_PACKETS  = 256;
	localparam int PAYLOAD_SIZE = 1024;
	localparam int ADDR_W       = $clog2(MAX_PACKETS);
	localparam int BASE_W       = ADDR_W + 1;

	localparam int SEQ_W    = 16;
	localparam int BYTES_W  = 11;
	localparam int OFFS_W   = 18;
	localparam int WBASE_W  = 9;
	localparam int TOTAL_W  = 19;
	localparam int WIN_W    = 5;
	localparam int STATUS_W = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
	localparam logic [WIN_W-1:0]   WIN_RESET  = WIN_W'(4);
	localparam logic [WIN_W-1:0]   WIN_MIN    = WIN_W'(1);
	localparam logic [WIN_W-1:0]   WIN_LIMIT  = WIN_W'(16);

	// register index of window_size (paddr[2])
	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DROP  = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_NEW   = 2'd2,
		STAT_RANGE = 2'd3
	} srr_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WALK_RD,
		ST_WALK,
		ST_FIN
	} srr_state_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total_bytes;
		logic                transfer_done;
		logic [WBASE_W-1:0]  window_base;
		logic [OFFS_W-1:0]   write_offset;
		logic                write_enable;
		logic [SEQ_W-1:0]    ack_number;
		logic                send_ack;
		srr_status_t         status;
	} srr_result_t;

endpackage
`default_nettype wire

### design/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### design/srr_apb.sv
// APB register block: holds window_size.
`default_nettype none
module srr_apb (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output logic      [srr_pkg::WIN_W-1:0] window_size
);
	import srr_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (wr_en) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	assign prdata      = (paddr[2] == REG_WINDOW) ? 32'(window_q) : 32'd0;
	assign window_size = window_q;

endmodule
`default_nettype wire

### design/srr_engine.sv
// Sequencer around the received bitmap: lookup, mark, base walk, clear sweep.
`default_nettype none
module srr_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [srr_pkg::WIN_W-1:0]   window_size,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [srr_pkg::SEQ_W-1:0]   in_seq,
	input  wire logic                        in_last,
	input  wire logic [srr_pkg::BYTES_W-1:0] in_bytes,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output srr_pkg::srr_result_t             res
);
	import srr_pkg::*;

	srr_state_t state_q, state_d;

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [SEQ_W-1:0]   seq_q;
	logic               last_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [BASE_W-1:0]  base_q;
	logic               last_known_q;
	logic [ADDR_W-1:0]  last_index_q;
	logic [TOTAL_W-1:0] total_q;
	srr_status_t        status_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [0:0]         ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [0:0]         ram_rdata;

	logic [WIN_W-1:0]   win_eff;
	logic [SEQ_W:0]     win_limit;
	logic               over_win;
	logic               beyond_map;
	logic [TOTAL_W:0]   total_sum;
	logic [BASE_W-1:0]  base_inc;
	logic               is_new;
	logic               done;
	logic               accept;

	srr_ram #(.WIDTH(1), .DEPTH(MAX_PACKETS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// window size clamped to 1..16
	always_comb begin
		if (window_size < WIN_MIN) begin
			win_eff = WIN_MIN;
		end else if (window_size > WIN_LIMIT) begin
			win_eff = WIN_LIMIT;
		end else begin
			win_eff = window_size;
		end
	end

	assign win_limit  = (SEQ_W+1)'(base_q) + (SEQ_W+1)'(win_eff);
	assign over_win   = {1'b0, seq_q} >= win_limit;
	assign beyond_map = seq_q >= SEQ_W'(MAX_PACKETS);
	assign total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(bytes_q);
	assign base_inc   = base_q + BASE_W'(1);
	assign is_new     = (status_q == STAT_NEW);
	assign done       = is_new && last_known_q && (base_q > BASE_W'(last_index_q));
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = seq_q[ADDR_W-1:0];
		ram_wdata = 1'b1;
		ram_raddr = in_seq[ADDR_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = 1'b0;
				if (clr_cnt_q == ADDR_W'(MAX_PACKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!over_win && !beyond_map && !ram_rdata[0]) begin
					ram_we  = 1'b1;
					state_d = ST_WALK_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WALK_RD: begin
				ram_raddr = base_q[ADDR_W-1:0];
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				ram_raddr = base_inc[ADDR_W-1:0];
				if (!ram_rdata[0] || base_inc == BASE_W'(MAX_PACKETS)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = done ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// per-transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			base_q       <= '0;
			last_known_q <= 1'b0;
			last_index_q <= '0;
			total_q      <= '0;
			status_q     <= STAT_DROP;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (state_q == ST_CHECK) begin
				priority if (over_win) begin
					status_q <= STAT_DROP;
				end else if (beyond_map) begin
					status_q <= STAT_RANGE;
				end else if (ram_rdata[0]) begin
					status_q <= STAT_DUP;
				end else begin
					status_q <= STAT_NEW;
					total_q  <= (total_sum > (TOTAL_W+1)'(TOTAL_MAX)) ?
						TOTAL_MAX : total_sum[TOTAL_W-1:0];
					if (last_q) begin
						last_known_q <= 1'b1;
						last_index_q <= seq_q[ADDR_W-1:0];
					end
				end
			end
			if (state_q == ST_WALK && ram_rdata[0]) begin
				base_q <= base_inc;
			end
			if (state_q == ST_FIN && res_ready && done) begin
				clr_cnt_q    <= '0;
				base_q       <= '0;
				last_known_q <= 1'b0;
				last_index_q <= '0;
				total_q      <= '0;
			end
		end
	end

	// captured header
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q   <= in_seq;
			last_q  <= in_last;
			bytes_q <= in_bytes;
		end
	end

	always_comb begin
		res.status        = status_q;
		res.send_ack      = (status_q == STAT_DUP) || is_new;
		res.ack_number    = res.send_ack ? seq_q : '0;
		res.write_enable  = is_new;
		res.write_offset  = is_new ? OFFS_W'(seq_q * PAYLOAD_SIZE) : '0;
		res.window_base   = WBASE_W'(base_q);
		res.transfer_done = done;
		res.total_bytes   = total_q;
	end

endmodule
`default_nettype wire

### design/selective_repeat_receiver.sv
// Sequence: a header taken in idle is checked against the received bitmap; dropped, duplicate
// and out-of-range packets go straight to the result, while a new packet is marked and the base
// then walks over 0..16 received entries through the single read port of the bitmap.
// One header is handled at a time: the next is taken only once the result is parked in the output register.
// Reset: asynchronous, active low; a clearing pass then runs over the bitmap before
// the first header is taken, and the same pass follows each completed transfer.
`default_nettype none
module selective_repeat_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// header stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // seq_number[15:0], payload_bytes[26:16], zero fill
	input  wire logic        s_axis_tlast,  // last_flag
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// send_ack[0], ack_number[16:1], write_enable[17], write_offset[35:18],
	// window_base[44:36], total_bytes[63:45]
	output logic [63:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // status
	output logic             m_axis_tlast,  // transfer_done
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import srr_pkg::*;

	logic [WIN_W-1:0] window_size;
	logic             res_valid;
	logic             res_ready;
	srr_result_t      res;
	srr_result_t      out_q;
	logic             out_valid_q;

	srr_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.window_size (window_size)
	);

	srr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_size),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_seq      (s_axis_tdata[SEQ_W-1:0]),
		.in_last     (s_axis_tlast),
		.in_bytes    (s_axis_tdata[SEQ_W+BYTES_W-1:SEQ_W]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: the engine moves on (idle, or the clearing pass) once its result is parked here.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.transfer_done;
	assign m_axis_tdata  = {out_q.total_bytes, out_q.window_base, out_q.write_offset,
		out_q.write_enable, out_q.ack_number, out_q.send_ack};

endmodule
`default_nettype wire

### design/srr_check.sv
// Port-level checks for the selective-repeat receiver, bound to the top level.
`default_nettype none
module srr_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);
	import srr_pkg::*;

	// one header in flight: no transfer right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("header taken while previous one in flight");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast)))
		else $error("stalled result changed");

	// acks and writes follow the status code; idle fields read zero
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[0] == (m_axis_tuser == STAT_DUP || m_axis_tuser == STAT_NEW))
			&& (m_axis_tdata[17] == (m_axis_tuser == STAT_NEW))
			&& (m_axis_tdata[0] || m_axis_tdata[16:1] == 16'd0)
			&& (m_axis_tdata[17] || m_axis_tdata[35:18] == 18'd0))
		else $error("result fields disagree with status");

	// completion only on a newly accepted packet, with the base moved past zero
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
			(m_axis_tuser == STAT_NEW && m_axis_tdata[44:36] != 9'd0))
		else $error("transfer done on a non-new packet");

endmodule

bind selective_repeat_receiver srr_check u_srr_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### verif/tb_selective_repeat_receiver.sv
// Self-checking testbench of the selective-repeat receiver: packet header stream in, verdict stream out.
`timescale 1ns / 100ps
module tb_selective_repeat_receiver;
	import srr_pkg::*;

	// watchdog: cycles with work pending but no transfer on either stream
	// (covers the bitmap clearing pass, the receiver hold-off and random stalls)
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 300;
	localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

	// one arriving packet header
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic               last;
		logic [BYTES_W-1:0] bytes;
	} pkt_hdr_t;

	// receiver bookkeeping: bitmap, base, last packet, byte count, window register
	typedef struct packed {
		logic [MAX_PACKETS-1:0] got;
		logic [BASE_W-1:0]      base;
		logic                   last_known;
		logic [ADDR_W-1:0]      last_idx;
		logic [TOTAL_W-1:0]     total;
		logic [WIN_W-1:0]       win;
	} rx_track_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // seq_number[15:0], payload_bytes[26:16], zero fill
	logic        s_axis_tlast = 1'b0;  // last_flag
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// send_ack[0], ack_number[16:1], write_enable[17], write_offset[35:18],
	// window_base[44:36], total_bytes[63:45]
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;  // status
	logic        m_axis_tlast;  // transfer_done
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pkt_hdr_t     header_q[$];   // headers waiting to be offered
	srr_result_t  verdict_q[$];  // predicted verdicts of accepted headers
	rx_track_t    seen_rx;       // receiver state as of the accepted headers
	rx_track_t    plan_rx;       // receiver state as of the queued headers
	int           queued;
	int           failures;
	int           results_seen;
	int           stall_cycles;
	int           hold_left;
	bit           hold_used;
	bit           steady_phase;  // no random idling on either side
	pkt_hdr_t     offer;
	srr_result_t  got_verdict;
	srr_result_t  want_verdict;

	selective_repeat_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// window register is clamped to 1..16 when used
	function automatic int unsigned eff_window(input logic [WIN_W-1:0] value);
		if (value < WIN_MIN)
			return WIN_MIN;
		if (value > WIN_LIMIT)
			return WIN_LIMIT;
		return value;
	endfunction

	// Verdict for one header; updates the tracked state in place.
	function automatic srr_result_t judge_header(inout rx_track_t st, input pkt_hdr_t h);
		srr_result_t   r;
		int unsigned   w;
		int unsigned   sum;
		logic [WIN_W-1:0] keep_win;
		w = eff_window(st.win);
		r = '0;
		r.status = STAT_DROP;
		if (h.seq >= st.base + w) begin
			r.status = STAT_DROP;  // window test comes first, state untouched
		end else if (h.seq >= MAX_PACKETS) begin
			r.status = STAT_RANGE;
		end else if (st.got[h.seq[ADDR_W-1:0]]) begin
			r.status = STAT_DUP;  // ack again, last flag and length ignored
			r.send_ack = 1'b1;
			r.ack_number = h.seq;
		end else begin
			r.status = STAT_NEW;
			r.send_ack = 1'b1;
			r.ack_number = h.seq;
			r.write_enable = 1'b1;
			r.write_offset = OFFS_W'(h.seq * PAYLOAD_SIZE);
			// latest new packet carrying the flag wins
			if (h.last) begin
				st.last_known = 1'b1;
				st.last_idx = h.seq[ADDR_W-1:0];
			end
			sum = st.total + h.bytes;
			st.total = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
			st.got[h.seq[ADDR_W-1:0]] = 1'b1;
			while (st.base < MAX_PACKETS && st.got[st.base[ADDR_W-1:0]])
				st.base++;
			r.transfer_done = st.last_known && (st.base > st.last_idx);
		end
		r.window_base = st.base;
		r.total_bytes = st.total;
		// completion reports the final values, then everything but the window clears
		if (r.transfer_done) begin
			keep_win = st.win;
			st = '0;
			st.win = keep_win;
		end
		return r;
	endfunction

	task automatic report_result(input string what, input srr_result_t want,
			input srr_result_t got);
		if (failures < 10)
			$display("%0t %s: status %0d/%0d ack %0b/%0b num %0d/%0d wen %0b/%0b off %0d/%0d",
				$time, what, want.status, got.status, want.send_ack, got.send_ack,
				want.ack_number, got.ack_number, want.write_enable, got.write_enable,
				want.write_offset, got.write_offset,
				"  base %0d/%0d done %0b/%0b total %0d/%0d (exp/act)",
				want.window_base, got.window_base, want.transfer_done, got.transfer_done,
				want.total_bytes, got.total_bytes);
		failures++;
	endtask

	// queue a header and keep the planning copy of the state in step
	task automatic queue_header(input int seq, input bit last, input int bytes);
		pkt_hdr_t    h;
		h.seq = SEQ_W'(seq);
		h.last = last;
		h.bytes = BYTES_W'(bytes);
		header_q.push_back(h);
		void'(judge_header(plan_rx, h));
		queued++;
	endtask

	// One session of n packets: mostly in-window new packets in random order,
	// mixed with duplicates, over-window drops, noise and out-of-range numbers.
	// Runs until the planned state reports completion.
	task automatic gen_session(input int n, input bit early_last);
		int unsigned w;
		int unsigned roll;
		int unsigned hi;
		int unsigned span;
		int unsigned off;
		int unsigned seq;
		int          bytes;
		bit          last;
		int          start;
		start = queued;
		while (plan_rx.base != 0 || plan_rx.got != '0 || queued == start) begin
			w = eff_window(plan_rx.win);
			roll = $urandom_range(99);
			case ($urandom_range(9))
				0: bytes = 0;
				1: bytes = PAYLOAD_SIZE;
				default: bytes = $urandom_range(PAYLOAD_SIZE);
			endcase
			last = $urandom_range(1);
			if (roll < 8 && plan_rx.base != 0) begin
				seq = $urandom_range(plan_rx.base - 1);
			end else if (roll < 16) begin
				seq = plan_rx.base + w + $urandom_range(30);
			end else if (roll < 20) begin
				seq = $urandom_range(65535, plan_rx.base + w);
			end else if (roll < 35 && plan_rx.base + w > MAX_PACKETS) begin
				seq = $urandom_range(MAX_PACKETS, plan_rx.base + w - 1);
			end else begin
				hi = (plan_rx.base + w < n) ? plan_rx.base + w - 1 : n - 1;
				span = hi - plan_rx.base + 1;
				off = $urandom_range(span - 1);
				seq = plan_rx.base;
				for (int k = 0; k < span; k++) begin
					seq = plan_rx.base + (off + k) % span;
					if (!plan_rx.got[seq[ADDR_W-1:0]])
						break;
				end
				last = (seq == n - 1) || (early_last && $urandom_range(99) < 3);
			end
			queue_header(seq, last, bytes);
			// a single-packet session completes and clears on its first header
			if (plan_rx.base == 0 && plan_rx.got == '0)
				break;
		end
	endtask

	// register write: setup cycle, access cycle, done once pready is seen
	task automatic write_window(input logic [WIN_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seen_rx.win = value;
		plan_rx.win = value;
	endtask

	// wait until every header is out and every verdict is in, then let the
	// bitmap clearing pass of a finished session run out
	task automatic drain;
		while (header_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [WIN_W-1:0] win, input int budget,
			input bit with_long, input bit steady);
		int start;
		steady_phase <= steady;
		write_window(win);
		if (with_long)
			gen_session(MAX_PACKETS, 1'b0);
		start = queued;
		while (queued - start < budget)
			gen_session($urandom_range(1, 24), 1'b1);
		drain();
	endtask

	// sender: new header when the slot is free, random gaps unless steady
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				offer.seq = s_axis_tdata[15:0];
				offer.bytes = s_axis_tdata[26:16];
				offer.last = s_axis_tlast;
				verdict_q.push_back(judge_header(seen_rx, offer));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (header_q.size() != 0 && (steady_phase || $urandom_range(99) >= 9)) begin
					offer = header_q.pop_front();
					s_axis_tdata <= {5'b0, offer.bytes, offer.seq};
					s_axis_tlast <= offer.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off while plenty of headers
	// are still queued so the block backs up and stalls its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_used && results_seen >= 200 && header_q.size() > 100) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady_phase || $urandom_range(99) >= 9;
			end
		end
	end

	// verdict checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_verdict.status = srr_status_t'(m_axis_tuser);
			got_verdict.send_ack = m_axis_tdata[0];
			got_verdict.ack_number = m_axis_tdata[16:1];
			got_verdict.write_enable = m_axis_tdata[17];
			got_verdict.write_offset = m_axis_tdata[35:18];
			got_verdict.window_base = m_axis_tdata[44:36];
			got_verdict.total_bytes = m_axis_tdata[63:45];
			got_verdict.transfer_done = m_axis_tlast;
			results_seen <= results_seen + 1;
			if (verdict_q.size() == 0) begin
				report_result("verdict with nothing expected", '0, got_verdict);
			end else begin
				want_verdict = verdict_q.pop_front();
				if (got_verdict !== want_verdict)
					report_result("verdict mismatch", want_verdict, got_verdict);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (header_q.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		seen_rx = '0;
		seen_rx.win = WIN_RESET;
		plan_rx = seen_rx;
		queued = 0;
		failures = 0;
		results_seen = 0;
		stall_cycles = 0;
		hold_left = 0;
		hold_used = 1'b0;
		steady_phase = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset window of 4
		queue_header(0, 1'b0, PAYLOAD_SIZE);  // new, base moves to 1
		queue_header(0, 1'b1, 5);             // duplicate, flag ignored
		queue_header(5, 1'b0, 3);             // first number over the window
		queue_header(65535, 1'b1, PAYLOAD_SIZE);
		queue_header(3, 1'b1, 0);             // ahead of base, marks the last
		queue_header(4, 1'b1, 7);             // later last flag takes over
		queue_header(2, 1'b0, 512);
		queue_header(3, 1'b0, 9);             // duplicate ahead of base
		queue_header(1, 1'b0, 1023);          // base walks past the last: done
		queue_header(0, 1'b1, 100);           // one-packet session
		queue_header(1, 1'b0, 0);
		queue_header(4, 1'b0, 1);             // over window on a fresh session
		queue_header(3, 1'b0, 2047 - PAYLOAD_SIZE);
		queue_header(0, 1'b0, 1);
		queue_header(2, 1'b1, 64);            // walk over 2 and 3, done
		drain();

		// random phases across window settings, clamped values included
		run_phase(WIN_W'(1), 160, 1'b0, 1'b0);
		run_phase(WIN_W'(16), 120, 1'b1, 1'b0);
		run_phase(WIN_W'(0), 150, 1'b0, 1'b1);
		run_phase(WIN_W'(31), 120, 1'b1, 1'b0);
		run_phase(WIN_W'(17), 180, 1'b0, 1'b0);
		run_phase(WIN_W'($urandom_range(2, 15)), 200, 1'b0, 1'b0);
		run_phase(WIN_W'($urandom_range(31)), 120, 1'b0, 1'b0);
		run_phase(WIN_RESET, 120, 1'b0, 1'b0);

		failures += verdict_q.size();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
